// File: rtl/pscfq_pkg.sv
// types, register indexes and verdict codes for the panel short-circuit fault qualifier
package pscfq_pkg;

	// width of the whole-seconds timestamp
	localparam int SEC_BITS = 32;
	localparam int MSEC_BITS = 10;
	localparam int SCORE_BITS = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_PROTECT_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCORE_THRESHOLD   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SELF_PROTECT_MS   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RESIDUE_LIMIT_SEC = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BURST_READ_MS     = 3'd4;

	// register reset values
	localparam logic [7:0]  RST_SCORE_THRESHOLD   = 8'd12;
	localparam logic [15:0] RST_SELF_PROTECT_MS   = 16'd2000;
	localparam logic [15:0] RST_RESIDUE_LIMIT_SEC = 16'd600;
	localparam logic [15:0] RST_BURST_READ_MS     = 16'd100;

	// seconds beyond which the millisecond distance is clamped
	localparam logic [6:0] DSEC_CLAMP = 7'd100;
	localparam logic [SCORE_BITS-1:0] SCORE_MAX = 8'hFF;

	// verdict codes
	localparam logic [1:0] VERDICT_MATCH     = 2'd0;
	localparam logic [1:0] VERDICT_TOLERATED = 2'd1;
	localparam logic [1:0] VERDICT_FAULT     = 2'd2;
	localparam logic [1:0] VERDICT_IGNORED   = 2'd3;

	typedef struct packed {
		logic [7:0]           read_byte;
		logic [7:0]           expected_byte;
		logic [SEC_BITS-1:0]  now_sec;
		logic [MSEC_BITS-1:0] now_msec;
		logic                 first_of_check;
	} item_t;

	typedef struct packed {
		logic [1:0]            verdict;
		logic                  short_latched;
		logic [SCORE_BITS-1:0] fault_score;
	} result_t;

endpackage

// File: rtl/panel_short_circuit_fault_qualifier_core.sv
// panel short-circuit fault qualifier: leaky fault score, tolerance window and short latch
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | in_valid / in_stall    | in_data  (item_t)
//  out     | out       | out_valid / out_stall  | out_data (result_t)
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item passes from transfer on in to its result on out through the input
// register, then through the judging logic into the result register.
// One item per cycle is sustained while out is not stalled; the score and fault
// time update with the result load, so the next item sees them at once.
// Reset clears the score, the short latch, the fault time and the registers to
// their defaults. A stall on out holds the result and backs up into in_stall
// only when the input register is also full. cfg_ready is always high.
module panel_short_circuit_fault_qualifier_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  pscfq_pkg::item_t                       in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output pscfq_pkg::result_t                     out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pscfq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [pscfq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import pscfq_pkg::*;

	// configuration registers
	logic        protect_enable_q;
	logic [7:0]  score_threshold_q;
	logic [15:0] self_protect_ms_q;
	logic [15:0] residue_limit_sec_q;
	logic [15:0] burst_read_ms_q;

	// block state
	logic [SCORE_BITS-1:0] score_q;
	logic                  short_flag_q;
	logic [SEC_BITS-1:0]   last_fault_sec_q;
	logic [MSEC_BITS-1:0]  last_fault_msec_q;
	logic                  check_ended_q;

	// pipeline registers
	logic    s1_valid_q;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;

	// judging logic
	logic                  advance;
	logic                  cfg_write;
	logic                  active;
	logic                  ended_eff;
	logic                  forward;
	logic [SEC_BITS-1:0]   dsec;
	logic                  residue_clear;
	logic [6:0]            dsec_clamped;
	logic [16:0]           dsec_ms;
	logic signed [17:0]    delta;
	logic                  in_window;
	logic [SCORE_BITS-1:0] score_base;
	logic [SCORE_BITS-1:0] score_up;
	logic                  mismatch;
	logic                  tolerate;
	logic                  latch_short;
	logic                  fault;
	logic [SCORE_BITS-1:0] score_n;
	logic                  short_flag_n;
	logic                  check_ended_n;
	result_t               res_n;

	// handshake
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !advance;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protect_enable_q    <= 1'b0;
			score_threshold_q   <= RST_SCORE_THRESHOLD;
			self_protect_ms_q   <= RST_SELF_PROTECT_MS;
			residue_limit_sec_q <= RST_RESIDUE_LIMIT_SEC;
			burst_read_ms_q     <= RST_BURST_READ_MS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PROTECT_ENABLE:    protect_enable_q    <= cfg_data[0];
				CFG_SCORE_THRESHOLD:   score_threshold_q   <= cfg_data[7:0];
				CFG_SELF_PROTECT_MS:   self_protect_ms_q   <= cfg_data;
				CFG_RESIDUE_LIMIT_SEC: residue_limit_sec_q <= cfg_data;
				CFG_BURST_READ_MS:     burst_read_ms_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// time distance to the last fault
	always_comb begin
		forward       = item_s1.now_sec >= last_fault_sec_q;
		dsec          = item_s1.now_sec - last_fault_sec_q;
		residue_clear = forward && (dsec > SEC_BITS'(residue_limit_sec_q));
		dsec_clamped  = (dsec > SEC_BITS'(DSEC_CLAMP)) ? DSEC_CLAMP : dsec[6:0];
		dsec_ms       = 17'(dsec_clamped) * 17'd1000;
		delta         = $signed({1'b0, dsec_ms}) + $signed(18'(item_s1.now_msec))
		                - $signed(18'(last_fault_msec_q));
		in_window     = forward && (delta < $signed({2'b00, self_protect_ms_q}))
		                && (delta > $signed({2'b00, burst_read_ms_q}));
	end

	// score update and verdict
	always_comb begin
		ended_eff   = check_ended_q && !(protect_enable_q && item_s1.first_of_check);
		active      = protect_enable_q && !ended_eff;
		score_base  = residue_clear ? '0 : score_q;
		score_up    = (score_base != SCORE_MAX) ? score_base + 1'b1 : score_base;
		mismatch    = item_s1.read_byte != item_s1.expected_byte;
		tolerate    = in_window && (score_up < score_threshold_q);
		fault       = active && mismatch && !tolerate;
		latch_short = fault && (score_up >= score_threshold_q);

		score_n       = score_q;
		short_flag_n  = short_flag_q;
		check_ended_n = (protect_enable_q && item_s1.first_of_check) ? 1'b0 : check_ended_q;
		res_n.verdict = VERDICT_IGNORED;
		if (active) begin
			if (!mismatch) begin
				score_n       = (score_base != '0) ? score_base - 1'b1 : score_base;
				res_n.verdict = VERDICT_MATCH;
			end else if (tolerate) begin
				score_n       = score_up;
				res_n.verdict = VERDICT_TOLERATED;
			end else begin
				score_n       = latch_short ? '0 : score_up;
				short_flag_n  = short_flag_q || latch_short;
				check_ended_n = 1'b1;
				res_n.verdict = VERDICT_FAULT;
			end
		end
		res_n.short_latched = protect_enable_q && short_flag_n;
		res_n.fault_score   = score_n;
	end

	// control state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			score_q       <= '0;
			short_flag_q  <= 1'b0;
			check_ended_q <= 1'b0;
			last_fault_sec_q  <= '0;
			last_fault_msec_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
			if (!in_stall) begin
				s1_valid_q <= in_valid;
			end
			if (advance && s1_valid_q) begin
				score_q       <= score_n;
				short_flag_q  <= short_flag_n;
				check_ended_q <= check_ended_n;
				if (fault) begin
					last_fault_sec_q  <= item_s1.now_sec;
					last_fault_msec_q <= item_s1.now_msec;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance && s1_valid_q) begin
			res_q <= res_n;
		end
	end

	// the input register only backs up when it holds an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !in_stall)
		else $error("in_stall raised with an empty input register");

	// an item that is not held moves into the result register
	a_item_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !in_stall |=> out_valid_q)
		else $error("item lost between input and result register");

	// the short latch never clears outside reset
	a_short_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		short_flag_q |=> short_flag_q)
		else $error("short-circuit latch cleared");

	// a reported fault ends the check
	a_fault_ends_check: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_valid_q && res_n.verdict == VERDICT_FAULT |=> check_ended_q)
		else $error("fault did not end the check");

	// a fault that latches short circuit leaves a cleared score
	a_latch_clears_score: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_valid_q && latch_short |=> score_q == '0 && short_flag_q)
		else $error("short latch without score clear");

endmodule

// File: tb/panel_short_circuit_fault_qualifier_core_tb.sv
// self-checking testbench for the panel short-circuit fault qualifier core
module panel_short_circuit_fault_qualifier_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pscfq_pkg::*;

	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 40;
	localparam int PLAN_ROWS = 26;
	localparam int CYCLE_LIMIT = 400000;
	// index outside the register map, must be dropped by the block
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;

	typedef struct {
		row_kind_e                kind;
		item_t                    item;
		bit                       has_want;
		result_t                  want;
		logic [CFG_IDX_BITS-1:0]  reg_idx;
		logic [CFG_DATA_BITS-1:0] reg_val;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	item_t                    in_data;
	logic                     out_valid;
	logic                     out_stall;
	result_t                  out_data;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// shadow of the configuration registers
	logic                  en_reg;
	logic [7:0]            thresh_reg;
	logic [15:0]           protect_ms_reg;
	logic [15:0]           residue_sec_reg;
	logic [15:0]           burst_ms_reg;

	// shadow of the qualifier state
	logic [SCORE_BITS-1:0] pred_score;
	logic                  pred_short;
	logic [SEC_BITS-1:0]   last_flt_sec;
	logic [MSEC_BITS-1:0]  last_flt_msec;
	logic                  pred_ended;

	result_t               awaited_results[$];
	plan_row_t             directed_plan[PLAN_ROWS];
	int                    fails;
	int                    cycles;
	int                    stall_left;
	bit                    idling;
	logic [SEC_BITS-1:0]   wall_sec;
	int unsigned           wall_ms;

	panel_short_circuit_fault_qualifier_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// judge one status byte and update the shadow state
	function automatic result_t qualify_byte(item_t it);
		result_t             r;
		logic                forward;
		logic [SEC_BITS-1:0] dsec;
		int                  delta;
		logic                in_window;
		if (en_reg && it.first_of_check)
			pred_ended = 1'b0;
		r.verdict = VERDICT_IGNORED;
		if (en_reg && !pred_ended) begin
			forward = it.now_sec >= last_flt_sec;
			dsec = forward ? it.now_sec - last_flt_sec : '0;
			in_window = 1'b0;
			// stale fault history clears the score
			if (forward && dsec > {16'd0, residue_sec_reg})
				pred_score = '0;
			if (forward) begin
				if (dsec > 100)
					dsec = 100;
				delta = int'(dsec) * 1000 + int'(it.now_msec) - int'(last_flt_msec);
				in_window = delta < int'(protect_ms_reg) && delta > int'(burst_ms_reg);
			end
			if (it.read_byte == it.expected_byte) begin
				if (pred_score != 0)
					pred_score = pred_score - 1'b1;
				r.verdict = VERDICT_MATCH;
			end else begin
				if (pred_score != SCORE_MAX)
					pred_score = pred_score + 1'b1;
				if (in_window && pred_score < thresh_reg) begin
					r.verdict = VERDICT_TOLERATED;
				end else begin
					if (pred_score >= thresh_reg) begin
						pred_short = 1'b1;
						pred_score = '0;
					end
					last_flt_sec = it.now_sec;
					last_flt_msec = it.now_msec;
					pred_ended = 1'b1;
					r.verdict = VERDICT_FAULT;
				end
			end
		end
		r.short_latched = en_reg & pred_short;
		r.fault_score = pred_score;
		return r;
	endfunction

	function automatic plan_row_t feed(logic [7:0] rd, logic [7:0] ex, logic [31:0] sec,
			logic [9:0] ms, logic first);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.item.read_byte = rd;
		row.item.expected_byte = ex;
		row.item.now_sec = sec;
		row.item.now_msec = ms;
		row.item.first_of_check = first;
		row.has_want = 1'b0;
		row.want = '0;
		row.reg_idx = '0;
		row.reg_val = '0;
		return row;
	endfunction

	function automatic plan_row_t feed_chk(logic [7:0] rd, logic [7:0] ex, logic [31:0] sec,
			logic [9:0] ms, logic first, result_t want);
		plan_row_t row;
		row = feed(rd, ex, sec, ms, first);
		row.has_want = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t poke(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] val);
		plan_row_t row;
		row = feed('0, '0, '0, '0, 1'b0);
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// next item of a well-formed stream on a wall clock, with some noise
	function automatic item_t next_item();
		item_t it;
		case ($urandom_range(0, 39))
			0: wall_sec = $urandom();
			1, 2: wall_sec = wall_sec - $urandom_range(0, 3);
			3: wall_sec = wall_sec + $urandom_range(300, 70000);
			4, 5, 6, 7: wall_ms = wall_ms + $urandom_range(200, 2500);
			default: wall_ms = wall_ms + $urandom_range(0, 150);
		endcase
		wall_sec = wall_sec + wall_ms / 1000;
		wall_ms = wall_ms % 1000;
		it.expected_byte = 8'($urandom);
		it.read_byte = ($urandom_range(0, 9) < 6) ? it.expected_byte : 8'($urandom);
		it.now_sec = wall_sec;
		it.now_msec = ($urandom_range(0, 29) == 0) ? 10'($urandom_range(1000, 1023))
			: 10'(wall_ms);
		it.first_of_check = pred_ended ? ($urandom_range(0, 4) != 0)
			: ($urandom_range(0, 9) == 0);
		// noise item
		if ($urandom_range(0, 9) == 0) begin
			it.read_byte = 8'($urandom);
			it.expected_byte = 8'($urandom);
			it.now_sec = $urandom();
			it.now_msec = 10'($urandom);
			it.first_of_check = 1'($urandom);
		end
		return it;
	endfunction

	// present one item and hold it until its transfer
	task automatic send_item(input item_t it);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// register write, valid is left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PROTECT_ENABLE:    en_reg = val[0];
			CFG_SCORE_THRESHOLD:   thresh_reg = val[7:0];
			CFG_SELF_PROTECT_MS:   protect_ms_reg = val;
			CFG_RESIDUE_LIMIT_SEC: residue_sec_reg = val;
			CFG_BURST_READ_MS:     burst_ms_reg = val;
			default: ;
		endcase
	endtask

	// compare one result transfer with the oldest expectation
	task automatic check_result(input result_t got);
		result_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result, actual verdict %0d short %0d score %0d",
				$time, got.verdict, got.short_latched, got.fault_score);
			fails++;
		end else begin
			want = awaited_results.pop_front();
			if (got.verdict !== want.verdict) begin
				$display("%0t: verdict mismatch, expected %0d, actual %0d",
					$time, want.verdict, got.verdict);
				fails++;
			end
			if (got.short_latched !== want.short_latched) begin
				$display("%0t: short_latched mismatch, expected %0d, actual %0d",
					$time, want.short_latched, got.short_latched);
				fails++;
			end
			if (got.fault_score !== want.fault_score) begin
				$display("%0t: fault_score mismatch, expected %0d, actual %0d",
					$time, want.fault_score, got.fault_score);
				fails++;
			end
		end
	endtask

	// result side: check transfers and stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_data);
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		item_t   it;
		result_t predicted;
		bit      writing;
		int      live;
		int      sent;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fails = 0;
		cycles = 0;
		stall_left = 0;
		idling = 1'b1;
		wall_sec = 32'd1000;
		wall_ms = 0;

		en_reg = 1'b0;
		thresh_reg = RST_SCORE_THRESHOLD;
		protect_ms_reg = RST_SELF_PROTECT_MS;
		residue_sec_reg = RST_RESIDUE_LIMIT_SEC;
		burst_ms_reg = RST_BURST_READ_MS;
		pred_score = '0;
		pred_short = 1'b0;
		last_flt_sec = '0;
		last_flt_msec = '0;
		pred_ended = 1'b0;

		directed_plan = '{
			// disabled after reset
			feed_chk(8'h00, 8'hFF, 32'd0, 10'd0, 1'b1, '{VERDICT_IGNORED, 1'b0, 8'd0}),
			poke(CFG_PROTECT_ENABLE, 16'h0001),
			feed_chk(8'hAA, 8'hAA, 32'd10, 10'd0, 1'b1, '{VERDICT_MATCH, 1'b0, 8'd0}),
			// far from the reset fault time: reported
			feed_chk(8'h00, 8'hFF, 32'd10, 10'd500, 1'b0, '{VERDICT_FAULT, 1'b0, 8'd1}),
			// check ended, no new check
			feed_chk(8'h00, 8'hFF, 32'd10, 10'd600, 1'b0, '{VERDICT_IGNORED, 1'b0, 8'd1}),
			// new check, 300 ms after the fault: tolerated
			feed_chk(8'hFF, 8'h00, 32'd10, 10'd800, 1'b1, '{VERDICT_TOLERATED, 1'b0, 8'd2}),
			feed_chk(8'hFF, 8'hFF, 32'd10, 10'd999, 1'b0, '{VERDICT_MATCH, 1'b0, 8'd1}),
			// millisecond field past 999
			feed(8'h01, 8'h02, 32'd10, 10'd1023, 1'b0),
			// clock going back
			feed(8'h55, 8'hAA, 32'd5, 10'd0, 1'b0),
			// residue time exceeded, seconds at the top
			feed(8'h80, 8'h80, 32'hFFFF_FFFF, 10'd999, 1'b1),
			// threshold zero with upper data bits set
			poke(CFG_SCORE_THRESHOLD, 16'hFF00),
			feed_chk(8'h00, 8'h01, 32'hFFFF_FFFF, 10'd999, 1'b1, '{VERDICT_FAULT, 1'b1, 8'd0}),
			poke(CFG_SCORE_THRESHOLD, 16'h00FF),
			poke(CFG_SELF_PROTECT_MS, 16'hFFFF),
			poke(CFG_BURST_READ_MS, 16'h0000),
			poke(CFG_RESIDUE_LIMIT_SEC, 16'hFFFF),
			poke(CFG_UNUSED_INDEX, 16'hFFFF),
			// zero distance is outside the window
			feed_chk(8'h00, 8'hFF, 32'hFFFF_FFFF, 10'd999, 1'b1, '{VERDICT_FAULT, 1'b1, 8'd1}),
			feed(8'hFF, 8'h00, 32'd0, 10'd0, 1'b1),
			feed(8'h12, 8'h12, 32'd0, 10'd1, 1'b1),
			// window upper bound is exclusive
			feed(8'h12, 8'h34, 32'd65, 10'd534, 1'b0),
			feed(8'h12, 8'h34, 32'd65, 10'd535, 1'b0),
			// disabled: new check flag has no effect
			poke(CFG_PROTECT_ENABLE, 16'hFFFE),
			feed(8'h00, 8'hFF, 32'd1, 10'd0, 1'b1),
			poke(CFG_PROTECT_ENABLE, 16'h0001),
			feed(8'h00, 8'h00, 32'd70, 10'd0, 1'b0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		writing = 1'b0;
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_WRITE) begin
				if (!writing)
					drain();
				write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_valid <= 1'b0;
				writing = 1'b0;
				predicted = qualify_byte(directed_plan[i].item);
				awaited_results.push_back(directed_plan[i].has_want ?
					directed_plan[i].want : predicted);
				send_item(directed_plan[i].item);
			end
		end

		// random phases, each under its own settings
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			idling = (ph != NUM_PHASES - 1);
			if (ph == NUM_PHASES - 1) begin
				write_reg(CFG_PROTECT_ENABLE, 16'h0001);
				write_reg(CFG_SCORE_THRESHOLD, {8'h00, RST_SCORE_THRESHOLD});
				write_reg(CFG_SELF_PROTECT_MS, RST_SELF_PROTECT_MS);
				write_reg(CFG_RESIDUE_LIMIT_SEC, RST_RESIDUE_LIMIT_SEC);
				write_reg(CFG_BURST_READ_MS, RST_BURST_READ_MS);
			end else begin
				write_reg(CFG_PROTECT_ENABLE, {15'($urandom), 1'(ph != 3)});
				case ($urandom_range(0, 3))
					0: write_reg(CFG_SCORE_THRESHOLD, {8'($urandom), 8'd0});
					1: write_reg(CFG_SCORE_THRESHOLD, {8'($urandom), 8'hFF});
					default: write_reg(CFG_SCORE_THRESHOLD,
						{8'($urandom), 8'($urandom_range(1, 20))});
				endcase
				case ($urandom_range(0, 3))
					0: write_reg(CFG_SELF_PROTECT_MS, 16'h0000);
					1: write_reg(CFG_SELF_PROTECT_MS, 16'hFFFF);
					default: write_reg(CFG_SELF_PROTECT_MS, 16'($urandom_range(300, 3000)));
				endcase
				case ($urandom_range(0, 3))
					0: write_reg(CFG_RESIDUE_LIMIT_SEC, 16'h0000);
					1: write_reg(CFG_RESIDUE_LIMIT_SEC, 16'hFFFF);
					default: write_reg(CFG_RESIDUE_LIMIT_SEC, 16'($urandom_range(1, 400)));
				endcase
				case ($urandom_range(0, 3))
					0: write_reg(CFG_BURST_READ_MS, 16'h0000);
					1: write_reg(CFG_BURST_READ_MS, 16'hFFFF);
					default: write_reg(CFG_BURST_READ_MS, 16'($urandom_range(0, 200)));
				endcase
				if ($urandom_range(0, 2) == 0)
					write_reg(CFG_UNUSED_INDEX, 16'($urandom));
			end
			cfg_valid <= 1'b0;
			live = 0;
			sent = 0;
			while (live < PHASE_ITEMS && sent < 4 * PHASE_ITEMS) begin
				it = next_item();
				predicted = qualify_byte(it);
				awaited_results.push_back(predicted);
				if (predicted.verdict != VERDICT_IGNORED)
					live++;
				sent++;
				send_item(it);
			end
		end

		// let the pipeline settle, then report
		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/pscfq_pkg.sv
rtl/panel_short_circuit_fault_qualifier_core.sv
tb/panel_short_circuit_fault_qualifier_core_tb.sv
